@@ design/prf_pkg.sv @@
package prf_pkg;

  localparam int unsigned ACTION_W    = 1;
  localparam int unsigned POS_X_W     = 10;
  localparam int unsigned POS_Y_W     = 9;
  localparam int unsigned RECT_W_W    = 10;
  localparam int unsigned RECT_H_W    = 9;
  localparam int unsigned COLOUR_W    = 3;
  localparam int unsigned RD_ADDR_W   = 18;
  localparam int unsigned DATA_W      = 8;

  localparam logic [ACTION_W-1:0] ACTION_FILL = 1'b0;
  localparam logic [ACTION_W-1:0] ACTION_READ = 1'b1;

  localparam logic [DATA_W-1:0] KEEP_EVEN_MASK = 8'b1100_0111;
  localparam logic [DATA_W-1:0] KEEP_ODD_MASK  = 8'b1111_1000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_ROW,
    ST_RUN,
    ST_DRAIN
  } prf_state_e;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [POS_X_W-1:0]   pos_x;
    logic [POS_Y_W-1:0]   pos_y;
    logic [RECT_W_W-1:0]  rect_width;
    logic [RECT_H_W-1:0]  rect_height;
    logic [COLOUR_W-1:0]  colour;
    logic [RD_ADDR_W-1:0] read_address;
  } item_t;

  typedef struct packed {
    logic              was_read;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

@@ design/packed_rect_fill.sv @@
// Rectangle fill engine over a packed framebuffer (two 3-bit pixels per byte,
// even pixel in bits 2:0, odd pixel in bits 5:3).
// Input channel: in_valid_i/in_ready_o with action, position, size, colour
// and read address. Output channel: out_valid_o/out_ready_i carrying
// was_read and read_data; every input beat yields exactly one output beat.
// Items are handled one at a time; in_ready_o is high only while the engine
// is idle and the output register is empty or being emptied in that cycle.
// Read: out_valid_o rises 1 cycle after the accepting edge.
// Fill: a setup state, then per clipped row a row state followed by run
// states that touch one byte each, then a drain state, after which
// out_valid_o rises. One byte per cycle is set by the single
// read-modify-write path through the frame memory.
// Empty or off-screen fills go from setup straight to drain. With out_ready_i
// high the next item can be taken in the cycle in which out_valid_o rises.
// After reset the frame memory is zeroed one byte per cycle, all
// SCREEN_WIDTH*SCREEN_HEIGHT/2 bytes (153600 by default), with in_ready_o low.
// A stalled receiver holds the result in the output register, and in_ready_o
// stays low until that beat is taken.
module packed_rect_fill #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [prf_pkg::ACTION_W-1:0]    action_i,
  input  logic [prf_pkg::POS_X_W-1:0]     pos_x_i,
  input  logic [prf_pkg::POS_Y_W-1:0]     pos_y_i,
  input  logic [prf_pkg::RECT_W_W-1:0]    rect_width_i,
  input  logic [prf_pkg::RECT_H_W-1:0]    rect_height_i,
  input  logic [prf_pkg::COLOUR_W-1:0]    colour_i,
  input  logic [prf_pkg::RD_ADDR_W-1:0]   read_address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            was_read_o,
  output logic [prf_pkg::DATA_W-1:0]      read_data_o
);

  import prf_pkg::*;

  localparam int unsigned FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 2;
  localparam int unsigned AW       = $clog2(FB_BYTES);

  item_t   item;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    idle;
  logic    done;
  logic    start;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_comb begin
    item.action       = action_i;
    item.pos_x        = pos_x_i;
    item.pos_y        = pos_y_i;
    item.rect_width   = rect_width_i;
    item.rect_height  = rect_height_i;
    item.colour       = colour_i;
    item.read_address = read_address_i;
  end

  assign in_ready_o = idle && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  prf_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FB_BYTES      (FB_BYTES),
    .AW            (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .idle_o      (idle),
    .done_o      (done),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  prf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FB_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) res_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign was_read_o  = res_q.was_read;
  assign read_data_o = res_q.read_data;

endmodule

@@ design/prf_ram.sv @@
module prf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/prf_ctrl.sv @@
module prf_ctrl #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  parameter int unsigned FB_BYTES      = (SCREEN_WIDTH * SCREEN_HEIGHT) / 2,
  parameter int unsigned AW            = $clog2(FB_BYTES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  prf_pkg::item_t          item_i,
  output logic                    idle_o,
  output logic                    done_o,
  output prf_pkg::result_t        res_o,
  output logic                    ram_we_o,
  output logic [AW-1:0]           ram_waddr_o,
  output logic [prf_pkg::DATA_W-1:0] ram_wdata_o,
  output logic [AW-1:0]           ram_raddr_o,
  input  logic [prf_pkg::DATA_W-1:0] ram_rdata_i
);

  import prf_pkg::*;

  localparam int unsigned PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned PW  = $clog2(PIX);
  localparam int unsigned BW  = PW - 1;

  localparam logic [10:0]   SW_L  = 11'(SCREEN_WIDTH);
  localparam logic [9:0]    SH_L  = 10'(SCREEN_HEIGHT);
  localparam logic [PW-1:0] SW_P  = PW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(FB_BYTES - 1);

  prf_state_e state_q, state_d;

  logic [AW-1:0]       clr_q;
  logic [POS_X_W-1:0]  x0_q;
  logic [POS_Y_W-1:0]  y0_q;
  logic [10:0]         w_q;
  logic [9:0]          h_left_q;
  logic [COLOUR_W-1:0] colour_q;
  logic                draw_q;
  logic                rd_oob_q;
  logic [PW-1:0]       p_row_q;
  logic [BW-1:0]       a_q;
  logic [BW-1:0]       last_q;
  logic                lead_odd_q;
  logic                trail_even_q;
  logic                first_q;
  logic                s1_valid_q;
  logic [AW-1:0]       s1_addr_q;
  logic                s1_even_q;
  logic                s1_odd_q;

  logic [10:0]   x_sum;
  logic [9:0]    y_sum;
  logic [10:0]   w_clip;
  logic [9:0]    h_clip;
  logic          draw_ok;
  logic [PW-1:0] p_end;
  logic          row_last;
  logic [DATA_W-1:0] merge_even;
  logic [DATA_W-1:0] merge_odd;

  // clip against right and bottom edges
  always_comb begin
    x_sum  = {1'b0, item_i.pos_x} + {1'b0, item_i.rect_width};
    y_sum  = {1'b0, item_i.pos_y} + {1'b0, item_i.rect_height};
    w_clip = (x_sum >= SW_L) ? (SW_L - {1'b0, item_i.pos_x}) : {1'b0, item_i.rect_width};
    h_clip = (y_sum >= SH_L) ? (SH_L - {1'b0, item_i.pos_y}) : {1'b0, item_i.rect_height};
    draw_ok = ({1'b0, item_i.pos_x} < SW_L) && ({1'b0, item_i.pos_y} < SH_L)
              && (w_clip != '0) && (h_clip != '0);
  end

  assign p_end    = p_row_q + PW'(w_q) - PW'(1);
  assign row_last = (a_q == last_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = (item_i.action == ACTION_READ) ? ST_READ : ST_SETUP;
      end
      ST_READ:  state_d = ST_IDLE;
      ST_SETUP: state_d = draw_q ? ST_ROW : ST_DRAIN;
      ST_ROW:   state_d = ST_RUN;
      ST_RUN: begin
        if (row_last) state_d = (h_left_q == 10'd1) ? ST_DRAIN : ST_ROW;
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    merge_even = s1_even_q ? ((ram_rdata_i & KEEP_ODD_MASK) | DATA_W'(colour_q)) : ram_rdata_i;
    merge_odd  = s1_odd_q ? ((merge_even & KEEP_EVEN_MASK) | (DATA_W'(colour_q) << 3))
                          : merge_even;
  end

  always_comb begin
    idle_o      = (state_q == ST_IDLE);
    done_o      = 1'b0;
    res_o       = '0;
    ram_we_o    = s1_valid_q;
    ram_waddr_o = s1_addr_q;
    ram_wdata_o = merge_odd;
    ram_raddr_o = a_q[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
      end
      ST_IDLE: begin
        ram_raddr_o = item_i.read_address[AW-1:0];
      end
      ST_READ: begin
        done_o          = 1'b1;
        res_o.was_read  = 1'b1;
        res_o.read_data = rd_oob_q ? '0 : ram_rdata_i;
      end
      ST_DRAIN: begin
        done_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= 1'b0;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == ST_RUN) s1_valid_q <= (32'(a_q) < FB_BYTES);
    end
  end

  // a row bubble (ST_ROW) keeps a read from meeting the write of the same byte
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x0_q     <= item_i.pos_x;
          y0_q     <= item_i.pos_y;
          w_q      <= w_clip;
          h_left_q <= h_clip;
          colour_q <= item_i.colour;
          draw_q   <= draw_ok;
          rd_oob_q <= (32'(item_i.read_address) >= FB_BYTES);
        end
      end
      ST_SETUP: begin
        p_row_q <= PW'(y0_q) * SW_P + PW'(x0_q);
      end
      ST_ROW: begin
        a_q          <= p_row_q[PW-1:1];
        last_q       <= p_end[PW-1:1];
        lead_odd_q   <= p_row_q[0];
        trail_even_q <= ~p_end[0];
        first_q      <= 1'b1;
      end
      ST_RUN: begin
        s1_addr_q <= a_q[AW-1:0];
        s1_even_q <= !(first_q && lead_odd_q);
        s1_odd_q  <= !(row_last && trail_even_q);
        a_q       <= a_q + BW'(1);
        first_q   <= 1'b0;
        if (row_last) begin
          h_left_q <= h_left_q - 10'd1;
          p_row_q  <= p_row_q + SW_P;
        end
      end
      default: ;
    endcase
  end

endmodule
